// ===== hdl/svd_pkg.sv =====
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types and constants of the stereo vibrato delay.
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int PHASE_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SPREAD = 2'd2;

    localparam logic [15:0] PHASE_STEP_RST = 16'd1000;

    // quarter-wave polynomial coefficients, Q15
    localparam logic [17:0] SIN_C1 = 18'd51472;
    localparam logic [17:0] SIN_C3 = 18'd21167;
    localparam logic [17:0] SIN_C5 = 18'd2611;

    typedef struct packed {
        logic [15:0] phase_step;
        logic [13:0] depth;
        logic [21:0] phase_spread;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_sample;

endpackage

// ===== hdl/svd_in_if.sv =====
// ----------------------------------------------------------------------------
// svd_in_if
// Input channel: one stereo sample pair per beat.
// ----------------------------------------------------------------------------
interface svd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== hdl/svd_out_if.sv =====
// ----------------------------------------------------------------------------
// svd_out_if
// Output channel: one delayed stereo sample pair per beat.
// ----------------------------------------------------------------------------
interface svd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== hdl/svd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// svd_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface svd_cfg_if;
    import svd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/stereo_vibrato_delay.sv =====
// ----------------------------------------------------------------------------
// stereo_vibrato_delay
// Stereo vibrato: sine-LFO modulated delay lines with linear interpolation.
// The single shared multiplier (7 products per channel) and the read-position
//   wrap step loop set the time per pair; a new input pair is taken only
//   after the previous result has moved into the output register.
// Reset: synchronous; then a clearing pass zeroes both delay lines
//   with input ready low. Config writes are taken at any time.
// ----------------------------------------------------------------------------
module stereo_vibrato_delay #(
    parameter int TAP_CENTER      = 50,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svd_in_if.sink    i_in,
    svd_out_if.source o_out,
    svd_cfg_if.sink   i_cfg
);
    import svd_pkg::*;

    t_cfg               r_cfg;
    logic               r_ovalid;
    logic signed [15:0] r_oleft;
    logic signed [15:0] r_oright;

    logic    w_in_ready;
    logic    w_res_valid;
    logic    w_out_free;
    t_sample w_in;
    t_sample w_res;

    assign w_in.left  = i_in.left_in;
    assign w_in.right = i_in.right_in;
    assign i_in.ready = w_in_ready;
    assign w_out_free = !r_ovalid || o_out.ready;

    svd_core #(
        .TAP_CENTER      (TAP_CENTER),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_in        (w_in),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_out_free),
        .o_res       (w_res)
    );

    // config registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= PHASE_STEP_RST;
            r_cfg.depth        <= '0;
            r_cfg.phase_spread <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg.data[15:0];
                CFG_DEPTH:        r_cfg.depth        <= i_cfg.data[13:0];
                CFG_PHASE_SPREAD: r_cfg.phase_spread <= i_cfg.data[21:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_oleft  <= w_res.left;
            r_oright <= w_res.right;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.left_out  = r_oleft;
    assign o_out.right_out = r_oright;

    // core holds a finished pair until the output register can take it
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && !w_out_free |=> w_res_valid)
        else $error("result dropped while output register full");

    // no new beat while a finished pair is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_in_ready)
        else $error("input ready while result pending");

    // clearing pass keeps input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_in_ready)
        else $error("input ready during clearing pass");
endmodule

// ===== hdl/svd_ram.sv =====
// ----------------------------------------------------------------------------
// svd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/svd_core.sv =====
// ----------------------------------------------------------------------------
// svd_core
// Sequencer around one shared 18x18 multiplier: sine LFO polynomial, depth
// scaling, read-position wrap and linear interpolation, left then right.
// ----------------------------------------------------------------------------
module svd_core #(
    parameter int TAP_CENTER      = 50,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  svd_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  svd_pkg::t_sample i_in,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output svd_pkg::t_sample o_res
);
    import svd_pkg::*;

    localparam int LINE_LEN = 2 * TAP_CENTER;
    localparam int AW       = $clog2(LINE_LEN);
    localparam int QW       = $clog2(3 * TAP_CENTER + 128) + 1;
    localparam int SB       = SINE_TABLE_BITS;
    localparam int XPAD     = 17 - SB;

    localparam logic signed [QW-1:0] LEN_Q  = QW'(LINE_LEN);
    localparam logic [QW-1:0]        BASE_Q = QW'(TAP_CENTER);
    localparam logic [AW-1:0]        LAST_A = AW'(LINE_LEN - 1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_SQ    = 12'b0000_0000_0100,
        S_C5    = 12'b0000_0000_1000,
        S_C3    = 12'b0000_0001_0000,
        S_C1    = 12'b0000_0010_0000,
        S_DEP   = 12'b0000_0100_0000,
        S_WRAP  = 12'b0000_1000_0000,
        S_RD1   = 12'b0001_0000_0000,
        S_RDW   = 12'b0010_0000_0000,
        S_MA    = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_ch, n_ch;
    logic [AW-1:0]        r_wi, n_wi;
    logic [PHASE_W-1:0]   r_lfo, n_lfo;
    logic [16:0]          r_x, n_x;
    logic [16:0]          r_x2, n_x2;
    logic                 r_neg, n_neg;
    logic signed [17:0]   r_t, n_t;
    logic signed [QW-1:0] r_q, n_q;
    logic [7:0]           r_frac, n_frac;
    logic [AW-1:0]        r_i1, n_i1;
    logic signed [24:0]   r_acc, n_acc;
    t_sample              r_res, n_res;

    logic [PHASE_W-1:0]   w_ph;
    logic [SB-1:0]        w_idx;
    logic [16:0]          w_xraw;
    logic [16:0]          w_x;
    logic signed [17:0]   w_ma, w_mb;
    logic signed [35:0]   w_prod;
    logic [17:0]          w_tq;
    logic [17:0]          w_tc;
    logic signed [25:0]   w_sum;
    logic [15:0]          w_rd, w_rd_l, w_rd_r;
    logic                 w_we;
    logic [15:0]          w_wd_l, w_wd_r;
    logic [AW-1:0]        w_raddr;

    svd_ram #(.WIDTH(16), .DEPTH(LINE_LEN)) u_line_l (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wi),
        .i_wdata (w_wd_l),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_l)
    );

    svd_ram #(.WIDTH(16), .DEPTH(LINE_LEN)) u_line_r (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wi),
        .i_wdata (w_wd_r),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_r)
    );

    // LFO phase of the current channel and quarter-wave argument
    always_comb begin
        w_ph   = r_ch ? (r_lfo - PHASE_W'(i_cfg.phase_spread))
                      : (r_lfo + PHASE_W'(i_cfg.phase_spread));
        w_idx  = w_ph[PHASE_W-1 -: SB];
        w_xraw = {2'b00, w_idx[SB-3:0], {XPAD{1'b0}}};
        w_x    = w_idx[SB-2] ? (17'd32768 - w_xraw) : w_xraw;
        w_rd   = r_ch ? w_rd_r : w_rd_l;
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQ: begin
                w_ma = {1'b0, w_x};
                w_mb = {1'b0, w_x};
            end
            S_C5: begin
                w_ma = SIN_C5;
                w_mb = {1'b0, r_x2};
            end
            S_C3: begin
                w_ma = r_t;
                w_mb = {1'b0, r_x2};
            end
            S_C1: begin
                w_ma = r_t;
                w_mb = {1'b0, r_x};
            end
            S_DEP: begin
                w_ma = {4'b0000, i_cfg.depth};
                w_mb = r_t;
            end
            S_RDW: begin
                w_ma = {{2{w_rd[15]}}, w_rd};
                w_mb = {9'd0, 9'd256 - {1'b0, r_frac}};
            end
            S_MA: begin
                w_ma = {{2{w_rd[15]}}, w_rd};
                w_mb = {10'd0, r_frac};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
        w_tq   = w_prod[32:15];
        w_tc   = (w_tq > 18'd32767) ? 18'd32767 : w_tq;
        w_sum  = {r_acc[24], r_acc} + w_prod[25:0] + 26'sd128;
    end

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_wi        = r_wi;
        n_lfo       = r_lfo;
        n_x         = r_x;
        n_x2        = r_x2;
        n_neg       = r_neg;
        n_t         = r_t;
        n_q         = r_q;
        n_frac      = r_frac;
        n_i1        = r_i1;
        n_acc       = r_acc;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        w_we        = 1'b0;
        w_wd_l      = '0;
        w_wd_r      = '0;
        w_raddr     = r_i1;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_wi == LAST_A) begin
                    n_wi    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_wi = r_wi + 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_we    = 1'b1;
                    w_wd_l  = i_in.left;
                    w_wd_r  = i_in.right;
                    n_ch    = 1'b0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_x     = w_x;
                n_neg   = w_idx[SB-1];
                n_x2    = w_prod[31:15];
                n_state = S_C5;
            end
            S_C5: begin
                n_t     = SIN_C3 - w_prod[32:15];
                n_state = S_C3;
            end
            S_C3: begin
                n_t     = SIN_C1 - w_prod[32:15];
                n_state = S_C1;
            end
            S_C1: begin
                n_t     = r_neg ? (18'd0 - w_tc) : w_tc;
                n_state = S_DEP;
            end
            S_DEP: begin
                n_frac  = w_prod[22:15];
                n_q     = {{(QW-AW){1'b0}}, r_wi} + BASE_Q
                        + {{(QW-8){w_prod[30]}}, w_prod[30:23]};
                n_state = S_WRAP;
            end
            S_WRAP: begin
                if (r_q[QW-1]) begin
                    n_q = r_q + LEN_Q;
                end else if (r_q >= LEN_Q) begin
                    n_q = r_q - LEN_Q;
                end else begin
                    w_raddr = r_q[AW-1:0];
                    n_i1    = (r_q[AW-1:0] == LAST_A) ? '0 : r_q[AW-1:0] + 1'b1;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                w_raddr = r_q[AW-1:0];
                n_state = S_RDW;
            end
            S_RDW: begin
                n_acc   = w_prod[24:0];
                n_state = S_MA;
            end
            S_MA: begin
                if (r_ch) begin
                    n_res.right = w_sum[23:8];
                    n_state     = S_DONE;
                end else begin
                    n_res.left = w_sum[23:8];
                    n_ch       = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_wi    = (r_wi == LAST_A) ? '0 : r_wi + 1'b1;
                    n_lfo   = r_lfo + PHASE_W'(i_cfg.phase_step);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ch    <= 1'b0;
            r_wi    <= '0;
            r_lfo   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_wi    <= n_wi;
            r_lfo   <= n_lfo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_x2   <= n_x2;
        r_neg  <= n_neg;
        r_t    <= n_t;
        r_q    <= n_q;
        r_frac <= n_frac;
        r_i1   <= n_i1;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    assign o_res = r_res;
endmodule
